>>> sv/voxel_boundary_face_triangles_macros.svh
// assertion macros used by the checker of the voxel face block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef VOXEL_BOUNDARY_FACE_TRIANGLES_MACROS_SVH
`define VOXEL_BOUNDARY_FACE_TRIANGLES_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define VBF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define VBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/vbf_pkg.sv
// types, constants and the face corner table of the voxel face block
// used by the channel interfaces and the top level
`default_nettype none

package vbf_pkg;

    localparam int MAX_DIM    = 32;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int DIM_W      = COORD_W + 1;
    localparam int ADDR_W     = 3 * COORD_W;
    localparam int NUM_VOXELS = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int DENS_W     = 16;
    localparam int FACE_W     = 3;
    localparam int NUM_FACES  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [DIM_W-1:0]      t_dim;
    typedef logic [DENS_W-1:0]     t_dens;
    typedef logic [FACE_W-1:0]     t_face;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_SIZE_X    = 2'd1;
    localparam t_cfg_idx CFG_SIZE_Y    = 2'd2;
    localparam t_cfg_idx CFG_SIZE_Z    = 2'd3;

    localparam t_dens THRESHOLD_RST = 16'd32768;
    localparam t_dim  SIZE_RST      = DIM_W'(MAX_DIM);

    // input word kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // size register saturated to the grid
    function automatic t_dim eff_size(input t_dim s);
        eff_size = (s > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : s;
    endfunction

    // corner offset of a face quad, bits {x, y, z}
    function automatic logic [2:0] quad_corner(input t_face face, input logic [1:0] corner);
        logic [11:0] row;
        case (face)
            3'd0:    row = {3'b000, 3'b010, 3'b011, 3'b001};
            3'd1:    row = {3'b100, 3'b101, 3'b111, 3'b110};
            3'd2:    row = {3'b000, 3'b001, 3'b101, 3'b100};
            3'd3:    row = {3'b010, 3'b110, 3'b111, 3'b011};
            3'd4:    row = {3'b000, 3'b100, 3'b110, 3'b010};
            3'd5:    row = {3'b001, 3'b011, 3'b111, 3'b101};
            default: row = '0;
        endcase
        case (corner)
            2'd0:    quad_corner = row[11:9];
            2'd1:    quad_corner = row[8:6];
            2'd2:    quad_corner = row[5:3];
            default: quad_corner = row[2:0];
        endcase
    endfunction

endpackage

`default_nettype wire

>>> sv/vbf_if.sv
// valid/ready channel interfaces of the voxel face block
// depends on vbf_pkg
`default_nettype none

// input word: load density or extract faces
interface vbf_in_if;
    import vbf_pkg::*;
    logic   valid;
    logic   ready;
    logic   kind;
    t_coord voxel_x;
    t_coord voxel_y;
    t_coord voxel_z;
    t_dens  density;
    modport source (output valid, kind, voxel_x, voxel_y, voxel_z, density, input ready);
    modport sink   (input valid, kind, voxel_x, voxel_y, voxel_z, density, output ready);
endinterface

// result word: one triangle
interface vbf_out_if;
    import vbf_pkg::*;
    logic  valid;
    logic  ready;
    t_face face;
    logic  second_triangle;
    t_dim  a_x, a_y, a_z;
    t_dim  b_x, b_y, b_z;
    t_dim  c_x, c_y, c_z;
    logic  last_of_run;
    modport source (output valid, face, second_triangle, a_x, a_y, a_z, b_x, b_y, b_z,
                    c_x, c_y, c_z, last_of_run, input ready);
    modport sink   (input valid, face, second_triangle, a_x, a_y, a_z, b_x, b_y, b_z,
                    c_x, c_y, c_z, last_of_run, output ready);
endinterface

// configuration register write
interface vbf_cfg_if;
    import vbf_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/voxel_boundary_face_triangles.sv
// voxel boundary face extraction: occupancy map, neighbour sequencer, triangle output
// depends on vbf_pkg and the channel interfaces in vbf_if.sv
//
// A load word stores one occupancy bit (density >= threshold) for a voxel of a 32x32x32
// grid; loads outside the configured size are dropped. An extract word of a solid voxel
// emits two triangles for each exposed face in the order -x,+x,-y,+y,-z,+z, with
// last_of_run set on the final one. Extract steps: the word is accepted in S_IDLE;
// S_READ makes seven occupancy reads through the single read port of the map, one per
// cycle; S_FIN finishes collecting the bits and S_MASK builds the exposed-face mask;
// S_EMIT then emits the triangles (up to twelve), passing over each unexposed face,
// closes the run and waits while the sink holds a triangle. The input stays not ready
// during an extract. The map has no reset; an extract must only touch voxels that were
// loaded. Config writes are always accepted and take effect at once.
`default_nettype none

module voxel_boundary_face_triangles (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vbf_in_if.sink      i_in_ch,
    vbf_out_if.source   o_out_ch,
    vbf_cfg_if.sink     i_cfg_ch
);
    import vbf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_MASK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // configuration registers
    t_dens r_threshold;
    t_dim  r_size_x, r_size_y, r_size_z;
    t_dim  eff_x, eff_y, eff_z;

    // sequencer
    logic [2:0]           r_state;
    t_coord               r_x, r_y, r_z;
    logic [2:0]           r_idx;
    logic                 r_cap_en;
    logic [2:0]           r_cap_idx;
    logic                 r_rd_ok;
    logic [NUM_FACES:0]   r_solid;
    logic [NUM_FACES-1:0] r_exposed;
    t_face                r_face;
    logic                 r_tri;

    // occupancy map
    logic mem [0:NUM_VOXELS-1];
    logic r_mem_q;

    logic  in_acc, out_free, load_ok, wr_en;
    t_addr wr_addr;
    t_face nb_face;
    t_dim  sel, stepped, nx, ny, nz;
    logic  rd_ok;
    t_addr rd_addr;
    logic  face_hit, is_last, emit_fire;
    logic [2:0] q0, q1, q2;

    // output register
    logic  r_out_valid;
    t_face r_o_face;
    logic  r_o_second, r_o_last;
    t_dim  r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_cx, r_cy, r_cz;

    assign eff_x = eff_size(r_size_x);
    assign eff_y = eff_size(r_size_y);
    assign eff_z = eff_size(r_size_z);

    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = (r_state == S_IDLE);
    assign in_acc         = i_in_ch.valid && i_in_ch.ready;
    assign out_free       = !r_out_valid || o_out_ch.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_size_x    <= SIZE_RST;
            r_size_y    <= SIZE_RST;
            r_size_z    <= SIZE_RST;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                CFG_THRESHOLD: r_threshold <= i_cfg_ch.data;
                CFG_SIZE_X:    r_size_x    <= i_cfg_ch.data[DIM_W-1:0];
                CFG_SIZE_Y:    r_size_y    <= i_cfg_ch.data[DIM_W-1:0];
                CFG_SIZE_Z:    r_size_z    <= i_cfg_ch.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // load path writes straight from the accepted word
    assign load_ok = ({1'b0, i_in_ch.voxel_x} < eff_x) && ({1'b0, i_in_ch.voxel_y} < eff_y)
                  && ({1'b0, i_in_ch.voxel_z} < eff_z);
    assign wr_en   = in_acc && (i_in_ch.kind == KIND_LOAD) && load_ok;
    assign wr_addr = {i_in_ch.voxel_z, i_in_ch.voxel_y, i_in_ch.voxel_x};

    // shared +/-1 step on the axis of the neighbour being read
    always_comb begin
        nb_face = r_idx - 3'd1;
        case (nb_face[2:1])
            2'd0:    sel = {1'b0, r_x};
            2'd1:    sel = {1'b0, r_y};
            default: sel = {1'b0, r_z};
        endcase
        stepped = nb_face[0] ? sel + 6'd1 : sel - 6'd1;
        nx = {1'b0, r_x};
        ny = {1'b0, r_y};
        nz = {1'b0, r_z};
        if (r_idx != 3'd0) begin
            case (nb_face[2:1])
                2'd0:    nx = stepped;
                2'd1:    ny = stepped;
                default: nz = stepped;
            endcase
        end
        // minus step from zero wraps high and fails the compare
        rd_ok   = (nx < eff_x) && (ny < eff_y) && (nz < eff_z);
        rd_addr = {nz[COORD_W-1:0], ny[COORD_W-1:0], nx[COORD_W-1:0]};
    end

    // map write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= (i_in_ch.density >= r_threshold);
        end
    end

    // map read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // triangle corners of the current face
    assign face_hit  = r_exposed[r_face];
    assign is_last   = r_tri && ((r_exposed & ~(NUM_FACES'(1) << r_face)) == '0);
    assign emit_fire = (r_state == S_EMIT) && (r_exposed != '0) && face_hit && out_free;
    assign q0 = quad_corner(r_face, 2'd0);
    assign q1 = quad_corner(r_face, r_tri ? 2'd2 : 2'd1);
    assign q2 = quad_corner(r_face, r_tri ? 2'd3 : 2'd2);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_cap_en    <= 1'b0;
            r_face      <= '0;
            r_tri       <= 1'b0;
            r_exposed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_en <= (r_state == S_READ);
            // result word valid: set on a new triangle, cleared when taken
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out_ch.valid && o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in_ch.kind == KIND_EXTRACT)) begin
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'(NUM_FACES)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_MASK;
                end
                S_MASK: begin
                    r_exposed <= r_solid[0] ? ~r_solid[NUM_FACES:1] : '0;
                    r_face    <= '0;
                    r_tri     <= 1'b0;
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_exposed == '0) begin
                        r_state <= S_IDLE;
                    end else if (!face_hit) begin
                        r_face <= r_face + 3'd1;
                    end else if (out_free) begin
                        if (r_tri) begin
                            r_exposed[r_face] <= 1'b0;
                            r_face            <= r_face + 3'd1;
                            r_tri             <= 1'b0;
                        end else begin
                            r_tri <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_in_ch.voxel_x;
            r_y <= i_in_ch.voxel_y;
            r_z <= i_in_ch.voxel_z;
        end
        r_rd_ok   <= rd_ok;
        r_cap_idx <= r_idx;
        if (r_cap_en) begin
            r_solid[r_cap_idx] <= r_rd_ok & r_mem_q;
        end
        if (emit_fire) begin
            r_o_face   <= r_face;
            r_o_second <= r_tri;
            r_o_last   <= is_last;
            r_ax <= {1'b0, r_x} + DIM_W'(q0[2]);
            r_ay <= {1'b0, r_y} + DIM_W'(q0[1]);
            r_az <= {1'b0, r_z} + DIM_W'(q0[0]);
            r_bx <= {1'b0, r_x} + DIM_W'(q1[2]);
            r_by <= {1'b0, r_y} + DIM_W'(q1[1]);
            r_bz <= {1'b0, r_z} + DIM_W'(q1[0]);
            r_cx <= {1'b0, r_x} + DIM_W'(q2[2]);
            r_cy <= {1'b0, r_y} + DIM_W'(q2[1]);
            r_cz <= {1'b0, r_z} + DIM_W'(q2[0]);
        end
    end

    // output channel
    assign o_out_ch.valid           = r_out_valid;
    assign o_out_ch.face            = r_o_face;
    assign o_out_ch.second_triangle = r_o_second;
    assign o_out_ch.last_of_run     = r_o_last;
    assign o_out_ch.a_x = r_ax;
    assign o_out_ch.a_y = r_ay;
    assign o_out_ch.a_z = r_az;
    assign o_out_ch.b_x = r_bx;
    assign o_out_ch.b_y = r_by;
    assign o_out_ch.b_z = r_bz;
    assign o_out_ch.c_x = r_cx;
    assign o_out_ch.c_y = r_cy;
    assign o_out_ch.c_z = r_cz;

endmodule

`default_nettype wire

>>> sv/vbf_checker.sv
// port-level checker of the voxel face block, attached by bind
// depends on voxel_boundary_face_triangles_macros.svh and the top level ports
`default_nettype none
`include "voxel_boundary_face_triangles_macros.svh"

module vbf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_kind,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_out_face,
    input wire logic       i_out_last
);

    // stalled result word holds
    `VBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_face) && $stable(i_out_last), "result word changed while stalled")

    // an extract word blocks the input on the next cycle
    `VBF_ASSERT_NEXT(a_extract_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_kind, !i_in_ready, "input ready right after an extract word")

    // a run in progress keeps the input closed
    `VBF_ASSERT_SAME(a_run_closed, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready, "input ready during a run")

    // a load word never produces a result
    `VBF_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_kind && !i_out_valid, !i_out_valid, "result after a load word")

endmodule

bind voxel_boundary_face_triangles vbf_checker u_vbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_kind   (i_in_ch.kind),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_face  (o_out_ch.face),
    .i_out_last  (o_out_ch.last_of_run)
);

`default_nettype wire
